[src/fpln_pkg.sv]
`timescale 1ns / 1ps

package fpln_pkg;

    localparam int FRAC_BITS = 5;
    localparam int LOG_TERMS = 5;

    localparam int VALUE_W = 32;
    localparam int OUT_W = 11;
    localparam int MANT_W = FRAC_BITS + 2;
    localparam int ACC_W = FRAC_BITS + 1;
    localparam int LG_W = FRAC_BITS + 6;
    localparam int MUL_W = LG_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int K_W = 7;
    localparam int K_LIMIT = 64;
    localparam int LV_W = $clog2(LOG_TERMS + 1);
    localparam int KD = 2 ** LV_W;
    localparam int NORM_W = 5;
    localparam int CNT_W = 5;

    localparam logic [31:0] LN2_Q32 = 32'hB17217F7;
    localparam logic [FRAC_BITS-1:0] LN2_FX = FRAC_BITS'(LN2_Q32 >> (32 - FRAC_BITS));

    localparam int PC_W = 5;
    localparam int PROG_LEN = 17;

    localparam logic [PC_W-1:0] A_WAIT = PC_W'(0);
    localparam logic [PC_W-1:0] A_NORM0 = PC_W'(1);
    localparam logic [PC_W-1:0] A_NORM1 = PC_W'(2);
    localparam logic [PC_W-1:0] A_NORM2 = PC_W'(3);
    localparam logic [PC_W-1:0] A_NORM3 = PC_W'(4);
    localparam logic [PC_W-1:0] A_NORM4 = PC_W'(5);
    localparam logic [PC_W-1:0] A_MANT = PC_W'(6);
    localparam logic [PC_W-1:0] A_LVL = PC_W'(7);
    localparam logic [PC_W-1:0] A_MTEST = PC_W'(8);
    localparam logic [PC_W-1:0] A_SQ = PC_W'(9);
    localparam logic [PC_W-1:0] A_NEXT = PC_W'(10);
    localparam logic [PC_W-1:0] A_ONE = PC_W'(11);
    localparam logic [PC_W-1:0] A_ZACC = PC_W'(12);
    localparam logic [PC_W-1:0] A_UNW = PC_W'(13);
    localparam logic [PC_W-1:0] A_SUM = PC_W'(14);
    localparam logic [PC_W-1:0] A_MULLN = PC_W'(15);
    localparam logic [PC_W-1:0] A_OUT = PC_W'(16);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_NORM,
        OP_MANT,
        OP_SQUARE,
        OP_NEXT,
        OP_ACC1,
        OP_ACC0,
        OP_UNW,
        OP_SUM,
        OP_MULLN,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_ZERO,
        C_DEPTH,
        C_MONE,
        C_MLOW,
        C_NOTLV0
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  tgt;
        logic [NORM_W-1:0] sh;
    } ctrl_t;

    typedef struct packed {
        logic in_zero;
        logic depth;
        logic mone;
        logic mlow;
        logic notlv0;
        logic stall;
    } status_t;

    function automatic ctrl_t mk_word(input op_t op, input cond_t cond,
                                      input logic [PC_W-1:0] tgt,
                                      input logic [NORM_W-1:0] sh);
        ctrl_t w;
        w.op = op;
        w.cond = cond;
        w.tgt = tgt;
        w.sh = sh;
        return w;
    endfunction

    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] addr);
        ctrl_t w;
        unique case (addr)
            A_WAIT:  w = mk_word(OP_WAIT, C_ZERO, A_OUT, NORM_W'(0));
            A_NORM0: w = mk_word(OP_NORM, C_NEVER, A_WAIT, NORM_W'(16));
            A_NORM1: w = mk_word(OP_NORM, C_NEVER, A_WAIT, NORM_W'(8));
            A_NORM2: w = mk_word(OP_NORM, C_NEVER, A_WAIT, NORM_W'(4));
            A_NORM3: w = mk_word(OP_NORM, C_NEVER, A_WAIT, NORM_W'(2));
            A_NORM4: w = mk_word(OP_NORM, C_NEVER, A_WAIT, NORM_W'(1));
            A_MANT:  w = mk_word(OP_MANT, C_NEVER, A_WAIT, NORM_W'(0));
            A_LVL:   w = mk_word(OP_NOP, C_DEPTH, A_ONE, NORM_W'(0));
            A_MTEST: w = mk_word(OP_NOP, C_MONE, A_ZACC, NORM_W'(0));
            A_SQ:    w = mk_word(OP_SQUARE, C_MLOW, A_SQ, NORM_W'(0));
            A_NEXT:  w = mk_word(OP_NEXT, C_ALWAYS, A_LVL, NORM_W'(0));
            A_ONE:   w = mk_word(OP_ACC1, C_ALWAYS, A_UNW, NORM_W'(0));
            A_ZACC:  w = mk_word(OP_ACC0, C_NEVER, A_WAIT, NORM_W'(0));
            A_UNW:   w = mk_word(OP_UNW, C_NOTLV0, A_UNW, NORM_W'(0));
            A_SUM:   w = mk_word(OP_SUM, C_NEVER, A_WAIT, NORM_W'(0));
            A_MULLN: w = mk_word(OP_MULLN, C_NEVER, A_WAIT, NORM_W'(0));
            A_OUT:   w = mk_word(OP_OUT, C_ALWAYS, A_WAIT, NORM_W'(0));
            default: w = mk_word(OP_NOP, C_ALWAYS, A_WAIT, NORM_W'(0));
        endcase
        return w;
    endfunction

endpackage

[src/fpln_seq.sv]
`timescale 1ns / 1ps

module fpln_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  fpln_pkg::status_t status,
    output fpln_pkg::ctrl_t   ctrl
);
    import fpln_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ctrl_t           word;
    logic            take;

    assign word = ucode_rom(pc_reg);
    assign ctrl = word;

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:  take = 1'b0;
            C_ALWAYS: take = 1'b1;
            C_ZERO:   take = status.in_zero;
            C_DEPTH:  take = status.depth;
            C_MONE:   take = status.mone;
            C_MLOW:   take = status.mlow;
            C_NOTLV0: take = status.notlv0;
            default:  take = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (status.stall)
        begin
            pc_next = pc_reg;
        end
        else if (take)
        begin
            pc_next = word.tgt;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= A_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

`ifndef ASSERT_OFF
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg < PC_W'(PROG_LEN))
        else $error("Step counter left the program.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        status.stall |=> pc_reg == $past(pc_reg))
        else $error("Step counter moved during a stall.");
`endif

endmodule

[src/fpln_dp.sv]
`timescale 1ns / 1ps

module fpln_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fpln_pkg::ctrl_t                      ctrl,
    output fpln_pkg::status_t                    status,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [fpln_pkg::VALUE_W-1:0]         value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [fpln_pkg::OUT_W-1:0]    log_value,
    output logic                                 zero_input
);
    import fpln_pkg::*;

    localparam logic [MANT_W-1:0] ONE_M = MANT_W'(1) << FRAC_BITS;
    localparam logic [MANT_W-1:0] TWO_M = MANT_W'(2) << FRAC_BITS;
    localparam logic [ACC_W-1:0] ONE_A = ACC_W'(1) << FRAC_BITS;

    logic [VALUE_W-1:0] x_reg, x_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [MANT_W-1:0]  m_reg, m_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [LV_W-1:0]    level_reg, level_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [LG_W-1:0]    lg2_reg, lg2_next;
    logic [OUT_W-1:0]   res_reg, res_next;
    logic               zero_reg, zero_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   log_value_reg, log_value_next;
    logic               zero_input_reg, zero_input_next;
    logic [K_W-1:0]     karr [KD];

    logic               accept;
    logic               out_free;
    logic [VALUE_W-1:0] norm_mask;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  prod;
    logic [K_W-1:0]     k_rd;
    logic [MANT_W-1:0]  unw_sum;
    logic [MANT_W-1:0]  unw_shift;

    assign in_ready = (ctrl.op == OP_WAIT);
    assign accept = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign norm_mask = ~({VALUE_W{1'b1}} >> ctrl.sh);

    assign mul_a = (ctrl.op == OP_MULLN) ? lg2_reg : MUL_W'(m_reg);
    assign mul_b = (ctrl.op == OP_MULLN) ? MUL_W'(LN2_FX) : MUL_W'(m_reg);
    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign k_rd = karr[level_reg - LV_W'(1)];
    assign unw_sum = MANT_W'(ONE_A) + MANT_W'(acc_reg);
    assign unw_shift = unw_sum >> k_rd;

    assign status.in_zero = (value == '0);
    assign status.depth = (level_reg == LV_W'(LOG_TERMS));
    assign status.mone = (m_reg == ONE_M);
    assign status.mlow = (m_reg < TWO_M) && (k_reg < K_W'(K_LIMIT));
    assign status.notlv0 = (level_reg != '0);
    assign status.stall = ((ctrl.op == OP_WAIT) && !in_valid)
                        || ((ctrl.op == OP_OUT) && !out_free);

    always_comb
    begin
        x_next = x_reg;
        n_next = n_reg;
        m_next = m_reg;
        k_next = k_reg;
        level_next = level_reg;
        acc_next = acc_reg;
        lg2_next = lg2_reg;
        res_next = res_reg;
        zero_next = zero_reg;
        out_valid_next = out_valid_reg && !out_ready;
        log_value_next = log_value_reg;
        zero_input_next = zero_input_reg;
        unique case (ctrl.op)
            OP_WAIT:
            begin
                if (accept)
                begin
                    x_next = value;
                    n_next = '0;
                    zero_next = (value == '0);
                end
            end
            OP_NORM:
            begin
                if ((x_reg & norm_mask) == '0)
                begin
                    x_next = x_reg << ctrl.sh;
                    n_next = n_reg + CNT_W'(ctrl.sh);
                end
            end
            OP_MANT:
            begin
                m_next = MANT_W'(x_reg[VALUE_W-1 -: FRAC_BITS+1]);
                k_next = '0;
                level_next = '0;
            end
            OP_SQUARE:
            begin
                if (status.mlow)
                begin
                    m_next = prod[FRAC_BITS +: MANT_W];
                    k_next = k_reg + K_W'(1);
                end
            end
            OP_NEXT:
            begin
                m_next = m_reg >> 1;
                level_next = level_reg + LV_W'(1);
                k_next = '0;
            end
            OP_ACC1:
            begin
                acc_next = ONE_A;
            end
            OP_ACC0:
            begin
                acc_next = '0;
            end
            OP_UNW:
            begin
                if (status.notlv0)
                begin
                    level_next = level_reg - LV_W'(1);
                    if (k_rd > K_W'(FRAC_BITS))
                    begin
                        acc_next = '0;
                    end
                    else
                    begin
                        acc_next = unw_shift[ACC_W-1:0];
                    end
                end
            end
            OP_SUM:
            begin
                lg2_next = (LG_W'(CNT_W'(31) - n_reg) << FRAC_BITS) + LG_W'(acc_reg);
            end
            OP_MULLN:
            begin
                res_next = prod[FRAC_BITS +: OUT_W];
            end
            OP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    log_value_next = zero_reg ? {OUT_W{1'b1}} : res_reg;
                    zero_input_next = zero_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            level_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            level_reg <= level_next;
            k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        n_reg <= n_next;
        m_reg <= m_next;
        acc_reg <= acc_next;
        lg2_reg <= lg2_next;
        res_reg <= res_next;
        zero_reg <= zero_next;
        log_value_reg <= log_value_next;
        zero_input_reg <= zero_input_next;
        if (ctrl.op == OP_NEXT)
        begin
            karr[level_reg] <= k_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign log_value = log_value_reg;
    assign zero_input = zero_input_reg;

`ifndef ASSERT_OFF
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LV_W'(LOG_TERMS))
        else $error("Refinement level went past its limit.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("A second transaction was taken while one was in work.");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && zero_input_reg) |-> (log_value_reg == {OUT_W{1'b1}}))
        else $error("Zero input did not give an all-ones result.");
`endif

endmodule

[src/fixed_point_natural_log.sv]
`timescale 1ns / 1ps

// Natural logarithm of a 32-bit unsigned integer in signed fixed point.
// The input channel (in_valid, in_ready, value) takes one transaction at a time.
// The output channel (out_valid, out_ready, log_value, zero_input) gives one
// result per input transaction, held in an output register.
// A microcoded sequencer steps a single datapath with one shared multiplier.
// After acceptance an item is normalized by shift steps and its mantissa taken.
// Each refinement level then squares the mantissa on the shared multiplier
// until it reaches two or the squaring limit (k squarings) and halves it.
// Once the deepest level is reached or the mantissa reaches one, the levels
// are unwound, then the sum is formed, scaled by ln2 and loaded for output.
// A zero input skips to the output with log_value all ones and zero_input set.
// The next transaction is accepted once the result has been loaded into the
// output register, even while that result still waits for out_ready.
// When out_ready stays low and a new result is ready, the sequencer holds
// until the output register frees.
// Reset clears the sequencer, the output valid flag, the level and the squaring
// count; the block keeps no other state between transactions.

module fixed_point_natural_log (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fpln_pkg::VALUE_W-1:0]      value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [fpln_pkg::OUT_W-1:0] log_value,
    output logic                              zero_input
);
    import fpln_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    fpln_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    fpln_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .status     (status),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .log_value  (log_value),
        .zero_input (zero_input)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import fpln_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES = 150;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [VALUE_W-1:0]      value;
        logic signed [OUT_W-1:0] log_value;
        logic                    zero_input;
    } ln_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [VALUE_W-1:0]       value;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [OUT_W-1:0]  log_value;
    logic                     zero_input;

    ln_result_t pending_logs[$];

    int unsigned sent_count;
    int unsigned zero_count;
    int unsigned checked_count;
    int unsigned mismatch_count;
    int unsigned error_count;
    int unsigned idle_cycles;

    int burst_left;
    int idle_pct;
    int max_gap;
    int stall_pct;
    int hold_len;

    fixed_point_natural_log dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .log_value  (log_value),
        .zero_input (zero_input)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic ln_result_t predict_ln(input logic [VALUE_W-1:0] v);
        ln_result_t r;
        logic [63:0] one_fx;
        logic [63:0] m;
        logic [63:0] tail;
        logic [63:0] lg2;
        logic [63:0] ln2_fx;
        logic [63:0] scaled;
        logic [63:0] weights [LOG_TERMS];
        logic [VALUE_W-1:0] norm;
        int msb;
        int depth;
        int k;
        bit done;
        r.value = v;
        r.log_value = '1;
        r.zero_input = 1'b1;
        if (v == '0)
        begin
            return r;
        end
        one_fx = 64'd1 << FRAC_BITS;
        msb = 0;
        for (int i = 0; i < VALUE_W; i++)
        begin
            if (v[i])
            begin
                msb = i;
            end
        end
        norm = v << (VALUE_W - 1 - msb);
        m = 64'(norm >> (VALUE_W - FRAC_BITS - 1));
        lg2 = 64'(msb) << FRAC_BITS;
        tail = one_fx;
        depth = 0;
        done = 1'b0;
        for (int lvl = 0; lvl < LOG_TERMS && !done; lvl++)
        begin
            if (m <= one_fx)
            begin
                tail = 64'd0;
                done = 1'b1;
            end
            else
            begin
                k = 0;
                while (m < 2 * one_fx && k < 64)
                begin
                    m = (m * m) >> FRAC_BITS;
                    k++;
                end
                weights[depth] = (k > FRAC_BITS) ? 64'd0 : (one_fx >> k);
                depth++;
                m = m / 2;
            end
        end
        for (int i = depth - 1; i >= 0; i--)
        begin
            tail = (weights[i] * (one_fx + tail)) >> FRAC_BITS;
        end
        lg2 = lg2 + tail;
        ln2_fx = 64'(LN2_Q32) >> (32 - FRAC_BITS);
        scaled = (ln2_fx * lg2) >> FRAC_BITS;
        r.log_value = scaled[OUT_W-1:0];
        r.zero_input = 1'b0;
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int s;
        s = $urandom_range(VALUE_W - 1);
        case ($urandom_range(9))
            0: v = '0;
            1: v = 32'd1 << s;
            2: v = (32'd1 << s) + 32'($urandom_range(3));
            3, 4: v = $urandom >> s;
            5: v = 32'($urandom_range(1, 255));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, max_gap) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        value <= v;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sent_count++;
        if (v == '0)
        begin
            zero_count++;
        end
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_logs.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed_values();
        logic [VALUE_W-1:0] vals [$];
        vals = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
                 32'h8400_0000, 32'h8400_0001, 32'hFC00_0000, 32'h0000_0021,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000, 32'h0000_002F,
                 32'hB504_F334, 32'h0000_00FF, 32'h0001_FFFF, 32'h4000_0001,
                 32'hC000_0000, 32'h0000_0007};
        idle_pct = 0;
        stall_pct = 0;
        foreach (vals[i])
        begin
            send_value(vals[i]);
        end
        wait_all_results();
    endtask

    task automatic test_random_values(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 200 == 0)
            begin
                idle_pct = $urandom_range(0, 80);
                max_gap = $urandom_range(1, 60);
                stall_pct = $urandom_range(0, 80);
            end
            send_value(random_value());
        end
    endtask

    task automatic test_output_backpressure();
        idle_pct = 0;
        stall_pct = 20;
        @(posedge clk);
        hold_len = 400;
        for (int i = 0; i < 40; i++)
        begin
            send_value(random_value());
        end
        wait_all_results();
    endtask

    task automatic test_pause_until_empty();
        idle_pct = 30;
        max_gap = 8;
        stall_pct = 40;
        for (int i = 0; i < 60; i++)
        begin
            send_value(random_value());
            if (i % 20 == 19)
            begin
                wait_all_results();
            end
        end
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 100; i++)
        begin
            send_value(random_value());
        end
        wait_all_results();
    endtask

    always @(negedge clk)
    begin
        if (hold_len > 0)
        begin
            out_ready <= 1'b0;
            hold_len <= hold_len - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        ln_result_t want;
        if (rst_n && in_valid && in_ready)
        begin
            pending_logs.push_back(predict_ln(value));
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_logs.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("Unexpected result: log_value=%0d zero_input=%0b",
                             log_value, zero_input);
                end
            end
            else
            begin
                want = pending_logs.pop_front();
                checked_count++;
                if (log_value !== want.log_value || zero_input !== want.zero_input)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("Mismatch for value 0x%08h: log_value %0d, expected %0d; zero_input %0b, expected %0b",
                                 want.value, log_value, want.log_value,
                                 zero_input, want.zero_input);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transaction.", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        value = '0;
        out_ready = 1'b0;
        sent_count = 0;
        zero_count = 0;
        checked_count = 0;
        mismatch_count = 0;
        error_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        idle_pct = 0;
        max_gap = 1;
        stall_pct = 0;
        hold_len = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_values();
        test_back_to_back();
        test_output_backpressure();
        test_random_values(1450);
        test_pause_until_empty();

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_logs.size() != 0)
        begin
            error_count += pending_logs.size();
            $display("%0d expected results never arrived.", pending_logs.size());
        end
        $display("Run covered %0d inputs (%0d zero) under random gaps, stalls and a long hold-off.",
                 sent_count, zero_count);
        $display("Checked %0d results, %0d mismatched.", checked_count, mismatch_count);
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
src/fpln_pkg.sv
src/fpln_seq.sv
src/fpln_dp.sv
src/fixed_point_natural_log.sv
tb/tb_top.sv
